>>> rtl/core/cwf_pkg.sv
// Shared constants and the sequencer state type for the factor test block.
// No dependencies.
package cwf_pkg;

  localparam int PRIME_BITS_DEF = 62;
  localparam int EXP_BITS_DEF   = 32;
  localparam int BASE_BITS      = 32;
  localparam int EBIT_W         = 5;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_REDB = 7'b0000010,
    ST_REDN = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

>>> rtl/core/cwf_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Standalone; driven by the top level sequencer.
module cwf_mulmod #(
  parameter int PB = 62,
  parameter int MB = 62
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PB-1:0] a,
  input  logic [MB-1:0] b,
  input  logic [PB-1:0] m,
  output logic          busy,
  output logic          done,
  output logic [PB-1:0] r
);

  localparam int CW = (MB > 1) ? $clog2(MB) : 1;

  logic [PB-1:0] ra;
  logic [MB-1:0] rb;
  logic [PB-1:0] rm;
  logic [CW-1:0] cnt;
  logic [PB:0]   dbl;
  logic [PB:0]   dred;
  logic [PB:0]   sum;
  logic [PB-1:0] step;

  always_comb begin
    dbl  = {r, 1'b0};
    dred = (dbl >= {1'b0, rm}) ? dbl - {1'b0, rm} : dbl;
    sum  = dred + {1'b0, ra};
    if (rb[cnt]) begin
      step = (sum >= {1'b0, rm}) ? PB'(sum - {1'b0, rm}) : PB'(sum);
    end else begin
      step = PB'(dred);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      r   <= step;
      cnt <= cnt - CW'(1);
    end else if (start) begin
      r   <= '0;
      ra  <= a;
      rb  <= b;
      rm  <= m;
      cnt <= CW'(MB - 1);
    end
  end

endmodule

>>> rtl/core/cullen_woodall_factor_test.sv
// Top level of the factor test: computes b^n * n^b mod p and flags +1/-1.
// Depends on cwf_pkg and cwf_mulmod.
//
// channel  signals                          direction
// in       in_valid/in_ready, prime/base/exponent   into the block
// out      out_valid/out_ready, divides_minus/plus  out of the block
//
// One item takes at most (2 + 2*64 + 1) = 131 modular products, each run in turn
// on the single bit-serial multiplier; the block takes no item meanwhile.
// A modulus below two skips the arithmetic and reports both flags low.
// Reset is synchronous and clears the sequencer and the output valid.
// A result still waiting on out_ready holds the next one, and the block, in its final state.
module cullen_woodall_factor_test
  import cwf_pkg::*;
#(
  parameter int PRIME_BITS = PRIME_BITS_DEF,
  parameter int EXP_BITS   = EXP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRIME_BITS-1:0] prime,
  input  logic [BASE_BITS-1:0]  base,
  input  logic [EXP_BITS-1:0]   exponent,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  divides_minus,
  output logic                  divides_plus
);

  localparam int PB = PRIME_BITS;
  localparam int MB = (PRIME_BITS > BASE_BITS) ? PRIME_BITS : BASE_BITS;

  state_t state;
  logic [PB-1:0] p;
  logic [BASE_BITS-1:0] bb;
  logic [EXP_BITS-1:0] nn;
  logic [PB-1:0] xb, xn, acc, pw1;
  logic second, no_residue, pend;
  logic [EBIT_W-1:0] ebit;
  logic [BASE_BITS-1:0] ecur;

  logic          mstart, mbusy, mdone;
  logic [PB-1:0] ma, mr;
  logic [MB-1:0] mb;

  assign in_ready = (state == ST_IDLE);
  assign ecur = second ? bb : BASE_BITS'(nn);

  always_comb begin
    ma = acc;
    mb = MB'(acc);
    case (state)
      ST_REDB: begin
        ma = PB'(1);
        mb = MB'(bb);
      end
      ST_REDN: begin
        ma = PB'(1);
        mb = MB'(nn);
      end
      ST_SQ:   ma = acc;
      ST_MUL:  ma = second ? xn : xb;
      ST_FIN:  ma = pw1;
      default: ma = acc;
    endcase
  end

  assign mstart = !pend && (state == ST_REDB || state == ST_REDN || state == ST_SQ ||
                            state == ST_MUL || state == ST_FIN);

  cwf_mulmod #(.PB(PB), .MB(MB)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .m(p),
    .busy(mbusy), .done(mdone), .r(mr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mdone) pend <= 1'b0;
      else if (mstart) pend <= 1'b1;
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            p          <= prime;
            bb         <= base;
            nn         <= exponent;
            no_residue <= (prime < PB'(2));
            acc        <= '0;
            state      <= (prime < PB'(2)) ? ST_DONE : ST_REDB;
          end
        end
        ST_REDB: begin
          if (mdone) begin
            xb    <= mr;
            state <= ST_REDN;
          end
        end
        ST_REDN: begin
          if (mdone) begin
            xn     <= mr;
            acc    <= PB'(1);
            ebit   <= EBIT_W'(BASE_BITS - 1);
            second <= 1'b0;
            state  <= ST_SQ;
          end
        end
        ST_SQ, ST_MUL: begin
          if (mdone) begin
            if (state == ST_SQ && ecur[ebit]) begin
              acc   <= mr;
              state <= ST_MUL;
            end else if (ebit != '0) begin
              acc   <= mr;
              ebit  <= ebit - EBIT_W'(1);
              state <= ST_SQ;
            end else if (!second) begin
              pw1    <= mr;
              acc    <= PB'(1);
              second <= 1'b1;
              ebit   <= EBIT_W'(BASE_BITS - 1);
              state  <= ST_SQ;
            end else begin
              acc   <= mr;
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (mdone) begin
            acc   <= mr;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            divides_minus <= !no_residue && (acc == PB'(1));
            divides_plus  <= !no_residue && (acc == p - PB'(1));
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pending: assert property (@(posedge clk) disable iff (rst) mdone |-> pend)
    else $error("multiplier finished without a pending request");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst) in_ready |-> !mbusy)
    else $error("multiplier busy while idle");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for cullen_woodall_factor_test: random and directed
// transfers, with the flags predicted from b^n * n^b mod p. Depends on cwf_pkg and cullen_woodall_factor_test.
module testbench;
  import cwf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = PRIME_BITS_DEF;
  localparam int EB = EXP_BITS_DEF;
  localparam int N_RANDOM = 400;
  localparam int PAUSE_AT = 30;
  localparam longint CYCLE_LIMIT = 64'd60_000_000;

  typedef struct {
    logic [PB-1:0]        p;
    logic [BASE_BITS-1:0] b;
    logic [EB-1:0]        n;
  } term_t;

  typedef struct {
    logic minus;
    logic plus;
  } flags_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PB-1:0] prime = '0;
  logic [BASE_BITS-1:0] base = '0;
  logic [EB-1:0] exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic divides_minus;
  logic divides_plus;

  term_t pend_q[$];
  flags_t flags_q[$];
  int n_total = 0;
  int n_sent = 0;
  int n_errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  longint cycles = 0;
  term_t nxt;

  cullen_woodall_factor_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .prime(prime), .base(base), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .divides_minus(divides_minus), .divides_plus(divides_plus)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mul_residue(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
    logic [127:0] prod;
    prod = a * b;
    return 64'(prod % m);
  endfunction

  function automatic logic [63:0] pow_residue(logic [63:0] x, logic [31:0] e,
                                              logic [63:0] m);
    logic [63:0] r;
    r = 64'd1 % m;
    for (int i = 31; i >= 0; i--) begin
      r = mul_residue(r, r, m);
      if (e[i]) r = mul_residue(r, x, m);
    end
    return r;
  endfunction

  function automatic flags_t predict_flags(term_t t);
    flags_t f;
    logic [63:0] m;
    logic [63:0] r;
    m = 64'(t.p);
    f.minus = 1'b0;
    f.plus = 1'b0;
    if (m >= 2) begin
      r = mul_residue(pow_residue(64'(t.b) % m, 32'(t.n), m),
                      pow_residue(64'(t.n) % m, t.b, m), m);
      f.minus = (r == 1);
      f.plus = (r == m - 1);
    end
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    if ((n_sent / 40) % 3 == 1) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch on %s: got %0b expected %0b", what, got, want);
    n_errors++;
  endtask

  task automatic push_term(logic [63:0] p, logic [31:0] b, logic [31:0] n);
    term_t t;
    t.p = PB'(p);
    t.b = b;
    t.n = EB'(n);
    pend_q.push_back(t);
    n_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        flags_q.push_back(predict_flags(term_t'{prime, base, exponent}));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0 && !(n_sent == PAUSE_AT && flags_q.size() != 0)) begin
          nxt = pend_q.pop_front();
          prime <= nxt.p;
          base <= nxt.b;
          exponent <= nxt.n;
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    flags_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (flags_q.size() == 0) begin
          $display("result transfer with no expectation pending");
          n_errors++;
        end else begin
          want = flags_q.pop_front();
          if (divides_minus !== want.minus)
            report_mismatch("divides_minus", divides_minus, want.minus);
          if (divides_plus !== want.plus)
            report_mismatch("divides_plus", divides_plus, want.plus);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if ((n_sent / 50) % 3 == 2) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        stall_left <= $urandom_range(20, 300);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int kind;
    logic [63:0] p;
    logic [31:0] b;
    logic [31:0] n;
    int small_primes[] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

    push_term(0, 5, 7);
    push_term(1, 5, 7);
    push_term(2, 3, 5);
    push_term(2, 4, 6);
    push_term(3, 2, 1);
    push_term(5, 2, 1);
    push_term(7, 0, 0);
    push_term(7, 1, 0);
    push_term(7, 14, 21);
    push_term(9, 2, 2);
    push_term(15, 7, 11);
    push_term(64'h3FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_term(64'd2305843009213693951, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_term(64'd2305843009213693951, 2, 1);
    push_term(64'h3FFF_FFFF_FFFF_FFFF, 2, 32'h8000_0000);
    push_term(64'h2AAA_AAAA_AAAA_AAAB, 32'h5555_5555, 32'hAAAA_AAAA);
    push_term(64'h1555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_term(64'd4294967311, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_term(13, 26, 3);
    push_term(1000003, 3, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        p = 64'(small_primes[$urandom_range(0, small_primes.size() - 1)]);
        b = $urandom_range(2, 60);
        n = $urandom_range(1, 60);
      end else if (kind < 7) begin
        p = 64'($urandom_range(3, 65535) | 1);
        b = $urandom;
        n = $urandom;
      end else begin
        p = {$urandom, $urandom};
        p = p | 1;
        b = $urandom;
        n = $urandom;
        if ($urandom_range(0, 3) == 0) b = $urandom_range(2, 255);
      end
      push_term(p, b, n);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (n_sent == n_total && flags_q.size() == 0);
    repeat (300) @(posedge clk);
    if (n_errors == 0 && flags_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
